// ----- rtl/core/tbpf_pkg.sv -----
package tbpf_pkg;

    localparam int VRAM_DEPTH    = 8192;
    localparam int VRAM_AW       = $clog2(VRAM_DEPTH);
    localparam int SCREEN_WIDTH  = 160;
    localparam int VISIBLE_LINES = 144;

    // input action codes
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_RENDER = 1'b1;

    // configuration register indexes
    localparam logic [2:0] CFG_LCD_CONTROL = 3'd0;
    localparam logic [2:0] CFG_SCROLL_Y    = 3'd1;
    localparam logic [2:0] CFG_SCROLL_X    = 3'd2;
    localparam logic [2:0] CFG_WINDOW_Y    = 3'd3;
    localparam logic [2:0] CFG_WINDOW_X    = 3'd4;
    localparam logic [2:0] CFG_BG_PALETTE  = 3'd5;

    localparam logic [7:0] LCD_CONTROL_RESET = 8'h91;
    localparam logic [7:0] BG_PALETTE_RESET  = 8'hFC;

    // lcd_control bit positions
    localparam int LCDC_BG_EN   = 0;
    localparam int LCDC_BG_MAP  = 3;
    localparam int LCDC_DATA    = 4;
    localparam int LCDC_WIN_EN  = 5;
    localparam int LCDC_WIN_MAP = 6;

    localparam logic [7:0] WIN_X_OFFSET = 8'd7;

    function automatic logic [7:0] grey_of(input logic [1:0] shade);
        logic [7:0] g;
        case (shade)
            2'd0:    g = 8'hFF;
            2'd1:    g = 8'hCC;
            2'd2:    g = 8'h77;
            default: g = 8'h00;
        endcase
        return g;
    endfunction

endpackage

// ----- rtl/core/tbpf_ram.sv -----
module tbpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             a_en,
    input  logic [AW-1:0]    a_addr,
    output logic [WIDTH-1:0] a_rdata,
    input  logic             b_en,
    input  logic [AW-1:0]    b_addr,
    output logic [WIDTH-1:0] b_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (a_en) begin
            a_rdata <= mem[a_addr];
        end
        if (b_en) begin
            b_rdata <= mem[b_addr];
        end
    end

endmodule

// ----- rtl/core/tile_background_pixel_fetch_top.sv -----
// Background / window tile pixel fetch.
//
// Input channel (s_*): an item either writes one byte of the 8 KiB video
// memory (action write) or renders one screen pixel (action render).
// Result channel (m_*): one transfer per render item, none per write item,
// carrying the pixel position, a drawn flag, the 2-bit shade and its grey level.
// Configuration channel (cfg_*): always ready; write only while idle.
//
// A render item is fetched in steps: the tile map entry is read first, then
// both bit planes of the tile row are read together on the two memory read
// ports, and the result register is loaded once it is free; the next item is
// taken the cycle after the result is loaded, so renders do not overlap.
//
// Reset sets the configuration registers to their defaults and empties the
// pipeline; video memory content is undefined until written. When the
// receiver stalls, a second finished pixel holds in the last stage and no
// new item is taken until the result register drains.
module tile_background_pixel_fetch_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [12:0] s_vram_addr,
    input  logic [7:0]  s_vram_data,
    input  logic [7:0]  s_pixel_x,
    input  logic [7:0]  s_line_y,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_x,
    output logic [7:0]  m_out_line,
    output logic        m_drawn,
    output logic [1:0]  m_shade,
    output logic [7:0]  m_grey_level,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import tbpf_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_TILE, ST_PIX} state_t;

    state_t state_reg;

    logic [7:0] lcd_control_reg, scroll_y_reg, scroll_x_reg;
    logic [7:0] window_y_reg, window_x_reg, bg_palette_reg;

    logic [7:0] px_reg, ly_reg;
    logic       draw_reg;
    logic [2:0] xfine_reg, yfine_reg;

    logic       m_valid_reg, m_drawn_reg;
    logic [7:0] m_out_x_reg, m_out_line_reg, m_grey_reg;
    logic [1:0] m_shade_reg;

    logic         s_fire, render_fire, ram_we;
    logic [7:0]   win_left, xpos, ypos;
    logic         use_window, drawable, map_hi;
    logic [VRAM_AW-1:0] map_addr, tile_base, plane0_addr, plane1_addr;
    logic         ram_a_en, ram_b_en;
    logic [VRAM_AW-1:0] ram_a_addr;
    logic [7:0]   ram_a_rdata, ram_b_rdata;
    logic [2:0]   bit_sel;
    logic [1:0]   color, shade;
    logic         out_free;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_fire    = s_valid && s_ready;
    assign render_fire = s_fire && (s_action == ACT_RENDER);
    assign ram_we    = s_fire && (s_action == ACT_WRITE);

    // pixel placement, worked out in the transfer cycle
    always_comb begin
        win_left   = window_x_reg - WIN_X_OFFSET;
        use_window = lcd_control_reg[LCDC_WIN_EN] && (window_y_reg <= s_line_y)
                     && (s_pixel_x >= win_left);
        drawable   = lcd_control_reg[LCDC_BG_EN]
                     && ({1'b0, s_pixel_x} < 9'(SCREEN_WIDTH))
                     && (s_line_y < 8'(VISIBLE_LINES));
        if (use_window) begin
            xpos   = s_pixel_x - win_left;
            ypos   = s_line_y - window_y_reg;
            map_hi = lcd_control_reg[LCDC_WIN_MAP];
        end else begin
            xpos   = s_pixel_x + scroll_x_reg;
            ypos   = s_line_y + scroll_y_reg;
            map_hi = lcd_control_reg[LCDC_BG_MAP];
        end
        // 0x1800 or 0x1C00 plus row * 32 plus column
        map_addr = {2'b11, map_hi, ypos[7:3], xpos[7:3]};
    end

    // tile row address from the map entry: unsigned from 0x0000, signed from 0x0800
    always_comb begin
        if (lcd_control_reg[LCDC_DATA]) begin
            tile_base = {1'b0, ram_a_rdata, 4'b0000};
        end else begin
            tile_base = {~ram_a_rdata[7], ram_a_rdata[7], ram_a_rdata[6:0], 4'b0000};
        end
        plane0_addr = tile_base | {{(VRAM_AW-4){1'b0}}, yfine_reg, 1'b0};
        plane1_addr = tile_base | {{(VRAM_AW-4){1'b0}}, yfine_reg, 1'b1};
    end

    assign ram_a_en   = render_fire || (state_reg == ST_TILE);
    assign ram_b_en   = (state_reg == ST_TILE);
    assign ram_a_addr = (state_reg == ST_TILE) ? plane0_addr : map_addr;

    tbpf_ram #(
        .WIDTH (8),
        .DEPTH (VRAM_DEPTH)
    ) u_vram (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (s_vram_addr),
        .wdata   (s_vram_data),
        .a_en    (ram_a_en),
        .a_addr  (ram_a_addr),
        .a_rdata (ram_a_rdata),
        .b_en    (ram_b_en),
        .b_addr  (plane1_addr),
        .b_rdata (ram_b_rdata)
    );

    always_comb begin
        bit_sel = 3'd7 - xfine_reg;
        color   = {ram_b_rdata[bit_sel], ram_a_rdata[bit_sel]};
        case (color)
            2'd0:    shade = bg_palette_reg[1:0];
            2'd1:    shade = bg_palette_reg[3:2];
            2'd2:    shade = bg_palette_reg[5:4];
            default: shade = bg_palette_reg[7:6];
        endcase
    end

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
            lcd_control_reg <= LCD_CONTROL_RESET;
            scroll_y_reg    <= 8'd0;
            scroll_x_reg    <= 8'd0;
            window_y_reg    <= 8'd0;
            window_x_reg    <= 8'd0;
            bg_palette_reg  <= BG_PALETTE_RESET;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_LCD_CONTROL: lcd_control_reg <= cfg_data;
                    CFG_SCROLL_Y:    scroll_y_reg    <= cfg_data;
                    CFG_SCROLL_X:    scroll_x_reg    <= cfg_data;
                    CFG_WINDOW_Y:    window_y_reg    <= cfg_data;
                    CFG_WINDOW_X:    window_x_reg    <= cfg_data;
                    CFG_BG_PALETTE:  bg_palette_reg  <= cfg_data;
                    default: ;
                endcase
            end

            // in the pixel stage a drained result is replaced, not dropped
            if (m_valid_reg && m_ready && state_reg != ST_PIX) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (render_fire) begin
                        px_reg    <= s_pixel_x;
                        ly_reg    <= s_line_y;
                        draw_reg  <= drawable;
                        xfine_reg <= xpos[2:0];
                        yfine_reg <= ypos[2:0];
                        state_reg <= ST_TILE;
                    end
                end
                ST_TILE: begin
                    state_reg <= ST_PIX;
                end
                ST_PIX: begin
                    // hold here until the result register is free
                    if (out_free) begin
                        m_valid_reg    <= 1'b1;
                        m_out_x_reg    <= px_reg;
                        m_out_line_reg <= ly_reg;
                        m_drawn_reg    <= draw_reg;
                        m_shade_reg    <= draw_reg ? shade : 2'd0;
                        m_grey_reg     <= draw_reg ? grey_of(shade) : 8'd0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_x      = m_out_x_reg;
    assign m_out_line   = m_out_line_reg;
    assign m_drawn      = m_drawn_reg;
    assign m_shade      = m_shade_reg;
    assign m_grey_level = m_grey_reg;

    a_load_from_pix: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_PIX))
        else $error("result loaded outside the pixel stage");

    a_undrawn_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_drawn_reg) |-> (m_shade_reg == 2'd0 && m_grey_reg == 8'd0))
        else $error("undrawn pixel carries a shade");

    a_grey_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_drawn_reg) |-> (m_grey_reg == grey_of(m_shade_reg)))
        else $error("grey level does not match shade");

    a_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_IDLE && !ram_b_en))
        else $error("memory write during a fetch");

    a_tile_to_pix: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TILE) |=> (state_reg == ST_PIX))
        else $error("plane read not followed by pixel stage");

endmodule

// ----- tb/tile_background_pixel_fetch_top_test.sv -----
`timescale 1ns / 100ps

module tile_background_pixel_fetch_top_test;

    import tbpf_pkg::*;

    localparam int          CYCLE_LIMIT  = 500000;
    localparam int          DRAIN_CYCLES = 8;
    localparam logic [12:0] MAP_LOW      = 13'h1800;
    localparam logic [12:0] MAP_HIGH     = 13'h1C00;
    localparam logic [12:0] SIGNED_TILES = 13'h0800;

    typedef struct packed {
        logic [7:0] x;
        logic [7:0] line;
        logic       drawn;
        logic [1:0] shade;
        logic [7:0] grey;
    } pixel_result_t;

    typedef struct {
        logic [12:0] map_addr;
        logic [7:0]  col;
        logic [7:0]  row;
    } fetch_pos_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_action;
    logic [12:0] s_vram_addr;
    logic [7:0]  s_vram_data;
    logic [7:0]  s_pixel_x;
    logic [7:0]  s_line_y;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_out_x;
    logic [7:0]  m_out_line;
    logic        m_drawn;
    logic [1:0]  m_shade;
    logic [7:0]  m_grey_level;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [7:0]  cfg_data;

    // shadow of the block's registers and video memory
    logic [7:0] lcd_ctl     = LCD_CONTROL_RESET;
    logic [7:0] scroll_y_r  = 8'd0;
    logic [7:0] scroll_x_r  = 8'd0;
    logic [7:0] window_y_r  = 8'd0;
    logic [7:0] window_x_r  = 8'd0;
    logic [7:0] palette_r   = BG_PALETTE_RESET;
    logic [7:0] vram_shadow [VRAM_DEPTH];
    bit         vram_known  [VRAM_DEPTH];

    pixel_result_t pending_pixels[$];
    pixel_result_t got_pixel;

    int error_count   = 0;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;

    tile_background_pixel_fetch_top u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_vram_addr  (s_vram_addr),
        .s_vram_data  (s_vram_data),
        .s_pixel_x    (s_pixel_x),
        .s_line_y     (s_line_y),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_x      (m_out_x),
        .m_out_line   (m_out_line),
        .m_drawn      (m_drawn),
        .m_shade      (m_shade),
        .m_grey_level (m_grey_level),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver: random stalls, or a counted hold-off when requested
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready = 1'b0;
            hold_left--;
        end else begin
            m_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic [7:0] grey_for_shade(input logic [1:0] shade);
        case (shade)
            2'd0:    return 8'hFF;
            2'd1:    return 8'hCC;
            2'd2:    return 8'h77;
            default: return 8'h00;
        endcase
    endfunction

    // pick background or window and the map entry that covers the pixel
    function automatic fetch_pos_t locate_tile(input logic [7:0] px, input logic [7:0] ly);
        fetch_pos_t pos;
        logic [7:0] win_left;
        logic       map_hi;
        win_left = window_x_r - WIN_X_OFFSET;
        if (lcd_ctl[LCDC_WIN_EN] && window_y_r <= ly && px >= win_left) begin
            pos.col = px - win_left;
            pos.row = ly - window_y_r;
            map_hi  = lcd_ctl[LCDC_WIN_MAP];
        end else begin
            pos.col = px + scroll_x_r;
            pos.row = ly + scroll_y_r;
            map_hi  = lcd_ctl[LCDC_BG_MAP];
        end
        pos.map_addr = (map_hi ? MAP_HIGH : MAP_LOW) + 13'({pos.row[7:3], 5'd0})
                       + 13'(pos.col[7:3]);
        return pos;
    endfunction

    function automatic logic [12:0] plane_addr(input logic [7:0] tile, input logic [7:0] row);
        if (lcd_ctl[LCDC_DATA])
            return {1'b0, tile, row[2:0], 1'b0};
        return SIGNED_TILES + 13'({tile ^ 8'h80, row[2:0], 1'b0});
    endfunction

    function automatic pixel_result_t shade_pixel(input logic [7:0] px, input logic [7:0] ly);
        pixel_result_t res;
        fetch_pos_t    pos;
        logic [12:0]   row_addr;
        logic [7:0]    lo_plane;
        logic [7:0]    hi_plane;
        logic [2:0]    bit_pos;
        logic [1:0]    color;
        res = '0;
        res.x    = px;
        res.line = ly;
        if (!lcd_ctl[LCDC_BG_EN] || px >= SCREEN_WIDTH || ly >= VISIBLE_LINES)
            return res;
        pos      = locate_tile(px, ly);
        row_addr = plane_addr(vram_shadow[pos.map_addr], pos.row);
        lo_plane = vram_shadow[row_addr];
        hi_plane = vram_shadow[row_addr + 13'd1];
        bit_pos  = 3'd7 - pos.col[2:0];
        color    = {hi_plane[bit_pos], lo_plane[bit_pos]};
        res.drawn = 1'b1;
        res.shade = palette_r[{color, 1'b0} +: 2];
        res.grey  = grey_for_shade(res.shade);
        return res;
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(input logic act, input logic [12:0] addr, input logic [7:0] data,
                             input logic [7:0] px, input logic [7:0] ly);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid     = 1'b1;
        s_action    = act;
        s_vram_addr = addr;
        s_vram_data = data;
        s_pixel_x   = px;
        s_line_y    = ly;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (act == ACT_WRITE) begin
            vram_shadow[addr] = data;
            vram_known[addr]  = 1'b1;
        end else begin
            pending_pixels.push_back(shade_pixel(px, ly));
        end
        @(negedge aclk);
    endtask

    task automatic send_write(input logic [12:0] addr, input logic [7:0] data);
        send_item(ACT_WRITE, addr, data, 8'($urandom), 8'($urandom));
    endtask

    // fill any unwritten byte the fetch will touch, then render
    task automatic render_pixel(input logic [7:0] px, input logic [7:0] ly);
        fetch_pos_t  pos;
        logic [12:0] row_addr;
        pos = locate_tile(px, ly);
        if (!vram_known[pos.map_addr]) send_write(pos.map_addr, 8'($urandom));
        row_addr = plane_addr(vram_shadow[pos.map_addr], pos.row);
        if (!vram_known[row_addr]) send_write(row_addr, 8'($urandom));
        if (!vram_known[row_addr + 13'd1]) send_write(row_addr + 13'd1, 8'($urandom));
        send_item(ACT_RENDER, 13'($urandom), 8'($urandom), px, ly);
    endtask

    task automatic wait_idle();
        s_valid = 1'b0;
        while (pending_pixels.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
        wait_idle();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_LCD_CONTROL: lcd_ctl    = value;
            CFG_SCROLL_Y:    scroll_y_r = value;
            CFG_SCROLL_X:    scroll_x_r = value;
            CFG_WINDOW_Y:    window_y_r = value;
            CFG_WINDOW_X:    window_x_r = value;
            CFG_BG_PALETTE:  palette_r  = value;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [7:0] expv, input logic [7:0] actv);
        if (actv !== expv) begin
            $error("%s mismatch: expected %0h, actual %0h", name, expv, actv);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                $error("result transfer with nothing expected: x %0d line %0d",
                       m_out_x, m_out_line);
                error_count++;
            end else begin
                got_pixel = pending_pixels.pop_front();
                check_field("out_x", got_pixel.x, m_out_x);
                check_field("out_line", got_pixel.line, m_out_line);
                check_field("drawn", 8'(got_pixel.drawn), 8'(m_drawn));
                check_field("shade", 8'(got_pixel.shade), 8'(m_shade));
                check_field("grey_level", got_pixel.grey, m_grey_level);
            end
        end
    end

    function automatic logic [7:0] rand_column();
        if ($urandom_range(9) == 0) return 8'($urandom_range(255, 160));
        return 8'($urandom_range(159, 0));
    endfunction

    function automatic logic [7:0] rand_line();
        if ($urandom_range(9) == 0) return 8'($urandom_range(255, 144));
        return 8'($urandom_range(143, 0));
    endfunction

    task automatic test_reset_defaults();
        render_pixel(8'd0, 8'd0);
        render_pixel(8'd159, 8'd143);
    endtask

    task automatic test_tile_data_select();
        // signed tile numbers at the ends and around the sign boundary
        write_reg(CFG_LCD_CONTROL, 8'h81);
        send_write(MAP_LOW + 13'd0, 8'h00);
        send_write(MAP_LOW + 13'd1, 8'h7F);
        send_write(MAP_LOW + 13'd2, 8'h80);
        send_write(MAP_LOW + 13'd3, 8'hFF);
        render_pixel(8'd0, 8'd0);
        render_pixel(8'd8, 8'd0);
        render_pixel(8'd16, 8'd0);
        render_pixel(8'd31, 8'd7);
        write_reg(CFG_LCD_CONTROL, 8'h99);
        render_pixel(8'd40, 8'd60);
    endtask

    task automatic test_scroll_extremes();
        write_reg(CFG_LCD_CONTROL, 8'h91);
        write_reg(CFG_SCROLL_X, 8'hFF);
        write_reg(CFG_SCROLL_Y, 8'hFF);
        render_pixel(8'd0, 8'd0);
        render_pixel(8'd159, 8'd143);
        write_reg(CFG_SCROLL_X, 8'h00);
        write_reg(CFG_SCROLL_Y, 8'h00);
    endtask

    task automatic test_window_placement();
        write_reg(CFG_LCD_CONTROL, 8'hB1);
        write_reg(CFG_WINDOW_Y, 8'd0);
        write_reg(CFG_WINDOW_X, 8'd7);
        render_pixel(8'd0, 8'd0);
        // window_x below seven wraps and hides the window
        write_reg(CFG_WINDOW_X, 8'd0);
        render_pixel(8'd159, 8'd20);
        write_reg(CFG_WINDOW_X, 8'd166);
        render_pixel(8'd158, 8'd10);
        render_pixel(8'd159, 8'd10);
        write_reg(CFG_WINDOW_X, 8'hFF);
        write_reg(CFG_WINDOW_Y, 8'd143);
        write_reg(CFG_LCD_CONTROL, 8'hF1);
        render_pixel(8'd5, 8'd142);
        write_reg(CFG_WINDOW_X, 8'd7);
        render_pixel(8'd5, 8'd143);
        write_reg(CFG_WINDOW_Y, 8'hFF);
        render_pixel(8'd80, 8'd143);
    endtask

    task automatic test_blanked_pixels();
        write_reg(CFG_LCD_CONTROL, 8'h90);
        render_pixel(8'd10, 8'd10);
        write_reg(CFG_LCD_CONTROL, 8'h91);
        render_pixel(8'd160, 8'd0);
        render_pixel(8'd0, 8'd144);
        render_pixel(8'd255, 8'd255);
    endtask

    task automatic test_palette_lookup();
        // planes 0x55 and 0x33 give colours 0..3 on the first four columns
        write_reg(CFG_LCD_CONTROL, 8'h91);
        send_write(MAP_LOW, 8'h00);
        send_write(13'd0, 8'h55);
        send_write(13'd1, 8'h33);
        write_reg(CFG_BG_PALETTE, 8'h1B);
        for (int col = 0; col < 4; col++) render_pixel(8'(col), 8'd0);
        write_reg(CFG_BG_PALETTE, 8'h00);
        render_pixel(8'd3, 8'd0);
        write_reg(CFG_BG_PALETTE, 8'hFF);
        render_pixel(8'd0, 8'd0);
    endtask

    task automatic randomise_config();
        logic [7:0] ctl;
        ctl = 8'($urandom);
        if ($urandom_range(9) != 0) ctl[LCDC_BG_EN] = 1'b1;
        write_reg(CFG_LCD_CONTROL, ctl);
        write_reg(CFG_SCROLL_Y, 8'($urandom));
        write_reg(CFG_SCROLL_X, 8'($urandom));
        write_reg(CFG_WINDOW_Y, ($urandom_range(7) == 0) ? 8'($urandom)
                                                          : 8'($urandom_range(150, 0)));
        write_reg(CFG_WINDOW_X, ($urandom_range(7) == 0) ? 8'($urandom)
                                                          : 8'($urandom_range(170, 0)));
        write_reg(CFG_BG_PALETTE, 8'($urandom));
    endtask

    task automatic test_random_traffic(input int n_items, input int send_idle, input int recv_idle);
        send_idle_pct = send_idle;
        recv_idle_pct = recv_idle;
        for (int i = 0; i < n_items; i++) begin
            if (i % 25 == 0) randomise_config();
            if ($urandom_range(99) < 20)
                send_write(13'($urandom), 8'($urandom));
            else
                render_pixel(rand_column(), rand_line());
        end
        wait_idle();
    endtask

    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        randomise_config();
        // hold the receiver off long enough for the input to stall
        hold_left = 300;
        for (int i = 0; i < 60; i++) render_pixel(rand_column(), rand_line());
        wait_idle();
    endtask

    task automatic test_drain_pause();
        send_idle_pct = 10;
        recv_idle_pct = 30;
        for (int i = 0; i < 20; i++) render_pixel(rand_column(), rand_line());
        wait_idle();
        for (int i = 0; i < 20; i++) render_pixel(rand_column(), rand_line());
        wait_idle();
    endtask

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_action    = ACT_WRITE;
        s_vram_addr = '0;
        s_vram_data = '0;
        s_pixel_x   = '0;
        s_line_y    = '0;
        m_ready     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_LCD_CONTROL;
        cfg_data    = '0;
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        test_reset_defaults();
        test_tile_data_select();
        test_scroll_extremes();
        test_window_placement();
        test_blanked_pixels();
        test_palette_lookup();
        test_random_traffic(100, 31, 62);
        test_random_traffic(100, 62, 31);
        test_output_backpressure();
        test_drain_pause();
        test_random_traffic(100, 0, 0);

        wait_idle();
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
